@@ hw/rtl/pce_pkg.sv @@
// Shared types, constants and character helpers for the path component codec.
`default_nettype none

package pce_pkg;

	localparam logic [7:0] UNDERSCORE  = 8'h5F;
	localparam int         QUEUE_DEPTH = 2;
	localparam int         JOB_WORDS   = 3;

	// One result word as it leaves the block
	typedef struct packed {
		logic [7:0] data;
		logic       vld;
		logic       last;
		logic       err;
	} word_t;

	// Up to three result words decided by the front for one input item
	typedef struct packed {
		logic [1:0]            cnt;
		word_t [JOB_WORDS-1:0] w;
	} job_t;

	// Queue status seen by the front and the back
	typedef struct packed {
		logic nempty;
		logic nfull;
	} q_stat_t;

	// Outcome of scanning one byte with nothing pending
	typedef struct packed {
		word_t w;
		logic  has;
		logic  hold;
	} scan_t;

	function automatic word_t mk_word(logic [7:0] d, logic vld, logic last, logic err);
		word_t r;
		r.data = vld ? d : 8'h00;
		r.vld  = vld;
		r.last = last;
		r.err  = err;
		return r;
	endfunction

	function automatic logic is_alnum(logic [7:0] b);
		return (b >= 8'h41 && b <= 8'h5A) || (b >= 8'h61 && b <= 8'h7A) ||
			(b >= 8'h30 && b <= 8'h39);
	endfunction

	function automatic logic is_hex(logic [7:0] b);
		return (b >= 8'h30 && b <= 8'h39) || (b >= 8'h61 && b <= 8'h66) ||
			(b >= 8'h41 && b <= 8'h46);
	endfunction

	function automatic logic [3:0] hex_val(logic [7:0] b);
		logic [7:0] t;
		t = 8'h00;
		if (b >= 8'h30 && b <= 8'h39) t = b - 8'h30;
		else if (b >= 8'h61 && b <= 8'h66) t = b - 8'h57;
		else if (b >= 8'h41 && b <= 8'h46) t = b - 8'h37;
		return t[3:0];
	endfunction

	// Lowercase hex character of a nibble
	function automatic logic [7:0] hex_digit(logic [3:0] v);
		return (v < 4'd10) ? (8'h30 + {4'h0, v}) : (8'h57 + {4'h0, v});
	endfunction

endpackage

`default_nettype wire

@@ hw/rtl/pce_front.sv @@
// Front end: takes input words, tracks escape state and decides the result words.
`default_nettype none

module pce_front import pce_pkg::*; (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	input  wire logic       in_empty,
	input  wire logic       cfg_valid,
	input  wire logic       cfg_ready,
	input  wire logic       direction,
	input  wire q_stat_t    q_stat,
	output logic            push,
	output job_t            push_job
);

	localparam logic [1:0] HELD_NONE  = 2'd0;
	localparam logic [1:0] HELD_UNDER = 2'd1;
	localparam logic [1:0] HELD_HEX   = 2'd2;

	logic       dir_q;
	logic [1:0] held_q;
	logic [7:0] held_byte_q;
	logic       at_start_q;

	logic       eff_last;
	logic       accept;
	logic [1:0] count;
	logic [1:0] next_held;
	logic       set_byte;
	job_t       job;
	scan_t      sp;

	// A byte with nothing pending: underscore is held or ends the component
	function automatic scan_t scan_plain(logic [7:0] b, logic last, logic whole);
		scan_t r;
		r.has  = 1'b1;
		r.hold = 1'b0;
		r.w    = mk_word(b, 1'b1, last, 1'b0);
		if (b == UNDERSCORE) begin
			if (last) begin
				r.w = mk_word(8'h00, 1'b0, 1'b1, !whole);
			end else begin
				r.has  = 1'b0;
				r.hold = 1'b1;
				r.w    = '0;
			end
		end
		return r;
	endfunction

	assign eff_last = in_last | in_empty;
	assign in_ready = q_stat.nfull;
	assign accept   = in_valid & in_ready;
	assign count    = (held_q == 2'd3) ? HELD_NONE : held_q;

	// Decide the result words of the offered item
	always_comb begin
		job       = '0;
		sp        = '0;
		next_held = HELD_NONE;
		set_byte  = 1'b0;
		if (!dir_q) begin
			// escape
			if (in_empty) begin
				job.cnt  = 2'd1;
				job.w[0] = at_start_q ? mk_word(UNDERSCORE, 1'b1, 1'b1, 1'b0)
					: mk_word(8'h00, 1'b0, 1'b1, 1'b0);
			end else if (is_alnum(in_byte)) begin
				job.cnt  = 2'd1;
				job.w[0] = mk_word(in_byte, 1'b1, eff_last, 1'b0);
			end else begin
				job.cnt  = 2'd3;
				job.w[0] = mk_word(UNDERSCORE, 1'b1, 1'b0, 1'b0);
				job.w[1] = mk_word(hex_digit(in_byte[7:4]), 1'b1, 1'b0, 1'b0);
				job.w[2] = mk_word(hex_digit(in_byte[3:0]), 1'b1, eff_last, 1'b0);
			end
		end else if (in_empty) begin
			// unescape, end of component with no byte
			job.cnt  = 2'd1;
			job.w[0] = mk_word(8'h00, 1'b0, 1'b1, count != HELD_NONE);
		end else begin
			unique case (count)
				HELD_NONE: begin
					sp        = scan_plain(in_byte, eff_last, at_start_q);
					next_held = sp.hold ? HELD_UNDER : HELD_NONE;
					job.cnt   = {1'b0, sp.has};
					job.w[0]  = sp.w;
				end
				HELD_UNDER: begin
					if (eff_last) begin
						job.cnt  = 2'd1;
						job.w[0] = mk_word(8'h00, 1'b0, 1'b1, 1'b1);
					end else if (is_hex(in_byte)) begin
						next_held = HELD_HEX;
						set_byte  = 1'b1;
					end else begin
						sp        = scan_plain(in_byte, 1'b0, 1'b0);
						next_held = sp.hold ? HELD_UNDER : HELD_NONE;
						job.cnt   = sp.has ? 2'd2 : 2'd1;
						job.w[0]  = mk_word(UNDERSCORE, 1'b1, 1'b0, 1'b0);
						job.w[1]  = sp.w;
					end
				end
				HELD_HEX: begin
					if (is_hex(held_byte_q) && is_hex(in_byte)) begin
						job.cnt  = 2'd1;
						job.w[0] = mk_word({hex_val(held_byte_q), hex_val(in_byte)},
							1'b1, eff_last, 1'b0);
					end else begin
						sp        = scan_plain(in_byte, eff_last, 1'b0);
						next_held = sp.hold ? HELD_UNDER : HELD_NONE;
						job.cnt   = sp.has ? 2'd3 : 2'd2;
						job.w[0]  = mk_word(UNDERSCORE, 1'b1, 1'b0, 1'b0);
						job.w[1]  = mk_word(held_byte_q, 1'b1, 1'b0, 1'b0);
						job.w[2]  = sp.w;
					end
				end
				default: begin
					job = '0;
				end
			endcase
		end
	end

	assign push     = accept && (job.cnt != 2'd0);
	assign push_job = job;

	// Direction register and per-component state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			dir_q       <= 1'b0;
			held_q      <= HELD_NONE;
			held_byte_q <= 8'h00;
			at_start_q  <= 1'b1;
		end else if (cfg_valid && cfg_ready) begin
			dir_q       <= direction;
			held_q      <= HELD_NONE;
			held_byte_q <= 8'h00;
			at_start_q  <= 1'b1;
		end else if (accept) begin
			if (eff_last) begin
				held_q      <= HELD_NONE;
				held_byte_q <= 8'h00;
				at_start_q  <= 1'b1;
			end else begin
				held_q     <= next_held;
				at_start_q <= 1'b0;
				if (set_byte) held_byte_q <= in_byte;
			end
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/pce_queue.sv @@
// Short job queue between front and back end.
`default_nettype none

module pce_queue import pce_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic push,
	input  wire job_t push_job,
	input  wire logic pop,
	output job_t      head,
	output q_stat_t   q_stat
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	job_t          mem_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] cnt_q;

	assign head          = mem_q[rd_ptr_q];
	assign q_stat.nempty = (cnt_q != '0);
	assign q_stat.nfull  = (cnt_q != FULL_CNT);

	// Storage
	always_ff @(posedge clk) begin
		if (push) mem_q[wr_ptr_q] <= push_job;
	end

	// Pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push) wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + 1'b1;
			if (pop)  rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + 1'b1;
			if (push && !pop)      cnt_q <= cnt_q + 1'b1;
			else if (pop && !push) cnt_q <= cnt_q - 1'b1;
		end
	end

endmodule

`default_nettype wire

@@ hw/rtl/pce_back.sv @@
// Back end: walks the words of each job into the output register.
`default_nettype none

module pce_back import pce_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire job_t head,
	input  wire q_stat_t q_stat,
	output logic      pop,
	output logic      res_valid,
	input  wire logic res_ready,
	output logic [7:0] out_byte,
	output logic       out_valid,
	output logic       out_last,
	output logic       out_error
);

	logic [1:0] idx_q;
	logic       res_valid_q;
	word_t      out_word_q;

	logic  load;
	logic  take;
	logic  last_word;
	word_t cur;

	assign load      = !res_valid_q || res_ready;
	assign take      = load && q_stat.nempty;
	assign last_word = (idx_q == head.cnt - 2'd1);
	assign pop       = take && last_word;

	// Word of the head job at the current index
	always_comb begin
		unique case (idx_q)
			2'd0:    cur = head.w[0];
			2'd1:    cur = head.w[1];
			2'd2:    cur = head.w[2];
			default: cur = '0;
		endcase
	end

	// Word index and output valid
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= 2'd0;
			res_valid_q <= 1'b0;
		end else begin
			if (load) res_valid_q <= q_stat.nempty;
			if (pop) idx_q <= 2'd0;
			else if (take) idx_q <= idx_q + 2'd1;
		end
	end

	// Output payload
	always_ff @(posedge clk) begin
		if (take) out_word_q <= cur;
	end

	assign res_valid = res_valid_q;
	assign out_byte  = out_word_q.data;
	assign out_valid = out_word_q.vld;
	assign out_last  = out_word_q.last;
	assign out_error = out_word_q.err;

endmodule

`default_nettype wire

@@ hw/rtl/path_component_escape_codec_core.sv @@
// Top level of the path component escape/unescape codec.
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------
//  input   | in_valid / in_ready  | in_byte, in_last, in_empty
//  result  | res_valid / res_ready| out_byte, out_valid, out_last, out_error
//  config  | cfg_valid / cfg_ready| direction
//
// At most one result word leaves per cycle. Each input word taken is turned into
// zero to three result words (none while an escape is still being gathered);
// the back end walks one word per cycle while the result side is ready, so
// multi-word jobs such as an escaped non-alphanumeric byte hold back the input,
// and single-word jobs run at one per cycle. The first result word passes
// through the job queue and then the output register before it is presented.
// Reset clears the queue, the result valid and the codec state; direction
// resets to escape. Input stalls only when the job queue is full.
`default_nettype none

module path_component_escape_codec_core import pce_pkg::*; #(
	parameter int DEPTH = QUEUE_DEPTH
) (
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire logic       in_valid,
	output logic            in_ready,
	input  wire logic [7:0] in_byte,
	input  wire logic       in_last,
	input  wire logic       in_empty,
	output logic            res_valid,
	input  wire logic       res_ready,
	output logic [7:0]      out_byte,
	output logic            out_valid,
	output logic            out_last,
	output logic            out_error,
	input  wire logic       cfg_valid,
	output logic            cfg_ready,
	input  wire logic       direction
);

	q_stat_t q_stat;
	logic    push;
	logic    pop;
	job_t    push_job;
	job_t    head;

	assign cfg_ready = 1'b1;

	pce_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.in_empty  (in_empty),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.direction (direction),
		.q_stat    (q_stat),
		.push      (push),
		.push_job  (push_job)
	);

	pce_queue #(.DEPTH(DEPTH)) u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_job (push_job),
		.pop      (pop),
		.head     (head),
		.q_stat   (q_stat)
	);

	pce_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.head      (head),
		.q_stat    (q_stat),
		.pop       (pop),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.out_byte  (out_byte),
		.out_valid (out_valid),
		.out_last  (out_last),
		.out_error (out_error)
	);

endmodule

`default_nettype wire

@@ hw/rtl/pce_checker.sv @@
// Port-level checks for the codec top level, bound to it.
`default_nettype none

module pce_checker (
	input wire logic       clk,
	input wire logic       arst_n,
	input wire logic       in_valid,
	input wire logic       in_ready,
	input wire logic       res_valid,
	input wire logic       res_ready,
	input wire logic [7:0] out_byte,
	input wire logic       out_valid,
	input wire logic       out_last,
	input wire logic       out_error
);

	// A stalled result word holds
	a_res_hold: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !res_ready |=> res_valid && $stable(out_byte) &&
		$stable(out_valid) && $stable(out_last) && $stable(out_error))
		else $error("result word changed while stalled");

	// A word without a byte always ends the component and carries zero
	a_bare_end: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && !out_valid |-> out_last && out_byte == 8'h00)
		else $error("byteless result word not a component end");

	// The error marker never carries a byte
	a_err_nobyte: assert property (@(posedge clk) disable iff (!arst_n)
		res_valid && out_error |-> !out_valid)
		else $error("error marker carries a byte");

	// The input side is never blocked while the result side stays empty and no input was offered
	a_no_stall: assert property (@(posedge clk) disable iff (!arst_n)
		!res_valid && $past(!res_valid) && $past(!in_valid) && arst_n |-> in_ready)
		else $error("input stalled with nothing queued");

endmodule

bind path_component_escape_codec_core pce_checker u_chk (.*);

`default_nettype wire

@@ tb/tb_path_component_escape_codec_core.sv @@
// Self-checking testbench for the path component escape/unescape codec core.
`timescale 1ns / 100ps

module tb_path_component_escape_codec_core;
	import pce_pkg::*;

	localparam int SETTLE_CYCLES  = 8;
	localparam int WATCHDOG_LIMIT = 3000;
	localparam int PHASE_WORDS    = 24;
	localparam int NUM_PHASES     = 8;

	localparam logic DIR_ESCAPE   = 1'b0;
	localparam logic DIR_UNESCAPE = 1'b1;

	// One input word: a byte of a component with its end marks
	typedef struct {
		logic [7:0] value;
		logic       last;
		logic       empty;
	} in_word_t;

	logic       clk       = 1'b0;
	logic       arst_n    = 1'b0;
	logic       in_valid  = 1'b0;
	logic       in_ready;
	logic [7:0] in_byte   = 8'h00;
	logic       in_last   = 1'b0;
	logic       in_empty  = 1'b0;
	logic       res_valid;
	logic       res_ready = 1'b0;
	logic [7:0] out_byte;
	logic       out_valid;
	logic       out_last;
	logic       out_error;
	logic       cfg_valid = 1'b0;
	logic       cfg_ready;
	logic       direction = 1'b0;

	in_word_t   in_word_q[$];
	in_word_t   comp_buf[$];
	word_t      pending_result_words[$];

	int         gap_pct      = 0;
	int         stall_pct    = 0;
	int         errors       = 0;
	int         idle_cycles  = 0;
	int         words_queued = 0;

	// Shadow of the codec state
	logic       cur_dir    = DIR_ESCAPE;
	logic [1:0] held_n     = 2'd0;
	logic [7:0] held_ch    = 8'h00;
	logic       comp_fresh = 1'b1;

	path_component_escape_codec_core dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_byte   (in_byte),
		.in_last   (in_last),
		.in_empty  (in_empty),
		.res_valid (res_valid),
		.res_ready (res_ready),
		.out_byte  (out_byte),
		.out_valid (out_valid),
		.out_last  (out_last),
		.out_error (out_error),
		.cfg_valid (cfg_valid),
		.cfg_ready (cfg_ready),
		.direction (direction)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// ---------------------------------------------------------------- helpers

	function automatic logic is_word_char(logic [7:0] c);
		return (c >= "0" && c <= "9") || (c >= "A" && c <= "Z") || (c >= "a" && c <= "z");
	endfunction

	// Value of a hex character, -1 if it is not one
	function automatic int nibble_of(logic [7:0] c);
		if (c >= "0" && c <= "9") return int'(c) - int'("0");
		if (c >= "a" && c <= "f") return int'(c) - int'("a") + 10;
		if (c >= "A" && c <= "F") return int'(c) - int'("A") + 10;
		return -1;
	endfunction

	function automatic logic [7:0] hex_char(logic [3:0] v, logic upper);
		if (v < 4'd10) return 8'h30 + {4'h0, v};
		return (upper ? 8'h41 : 8'h61) + {4'h0, v} - 8'd10;
	endfunction

	task automatic add_word(logic [7:0] d, logic v, logic l, logic e);
		word_t w;
		w.data = v ? d : 8'h00;
		w.vld  = v;
		w.last = l;
		w.err  = e;
		pending_result_words.push_back(w);
	endtask

	// A byte seen with nothing pending in unescape
	task automatic scan_free(logic [7:0] c, logic l, logic whole);
		if (c == UNDERSCORE) begin
			if (l) add_word(8'h00, 1'b0, 1'b1, !whole);
			else held_n = 2'd1;
		end else begin
			add_word(c, 1'b1, l, 1'b0);
		end
	endtask

	// Expected result words for one accepted input word
	task automatic codec_step(logic [7:0] c, logic lst, logic emp);
		logic       l;
		logic [1:0] cnt;
		int         hv;
		int         lv;
		l = lst | emp;
		if (cur_dir == DIR_ESCAPE) begin
			if (emp) begin
				if (comp_fresh) add_word(UNDERSCORE, 1'b1, 1'b1, 1'b0);
				else add_word(8'h00, 1'b0, 1'b1, 1'b0);
			end else if (is_word_char(c)) begin
				add_word(c, 1'b1, l, 1'b0);
			end else begin
				add_word(UNDERSCORE, 1'b1, 1'b0, 1'b0);
				add_word(hex_char(c[7:4], 1'b0), 1'b1, 1'b0, 1'b0);
				add_word(hex_char(c[3:0], 1'b0), 1'b1, l, 1'b0);
			end
		end else begin
			cnt = (held_n == 2'd3) ? 2'd0 : held_n;
			held_n = 2'd0;
			if (emp) begin
				add_word(8'h00, 1'b0, 1'b1, cnt != 2'd0);
			end else if (cnt == 2'd0) begin
				scan_free(c, l, comp_fresh);
			end else if (cnt == 2'd1) begin
				if (l) begin
					add_word(8'h00, 1'b0, 1'b1, 1'b1);
				end else if (nibble_of(c) >= 0) begin
					held_ch = c;
					held_n  = 2'd2;
				end else begin
					add_word(UNDERSCORE, 1'b1, 1'b0, 1'b0);
					scan_free(c, 1'b0, 1'b0);
				end
			end else begin
				hv = nibble_of(held_ch);
				lv = nibble_of(c);
				if (hv >= 0 && lv >= 0) begin
					add_word({hv[3:0], lv[3:0]}, 1'b1, l, 1'b0);
				end else begin
					add_word(UNDERSCORE, 1'b1, 1'b0, 1'b0);
					add_word(held_ch, 1'b1, 1'b0, 1'b0);
					scan_free(c, l, 1'b0);
				end
			end
		end
		// a finished component starts the next one clean
		if (l) begin
			held_n     = 2'd0;
			held_ch    = 8'h00;
			comp_fresh = 1'b1;
		end else begin
			comp_fresh = 1'b0;
		end
	endtask

	// ---------------------------------------------------------------- stimulus helpers

	task automatic push_word(logic [7:0] v, logic l, logic e);
		in_word_t w;
		w.value = v;
		w.last  = l;
		w.empty = e;
		in_word_q.push_back(w);
		words_queued++;
	endtask

	function automatic logic [7:0] pick_word_char();
		int r;
		r = $urandom_range(0, 61);
		if (r < 10) return 8'h30 + 8'(r);
		if (r < 36) return 8'h41 + 8'(r - 10);
		return 8'h61 + 8'(r - 36);
	endfunction

	// Mostly underscores and hex characters so that escapes get formed
	function automatic logic [7:0] pick_noise_char();
		int r;
		r = $urandom_range(0, 9);
		if (r < 3) return UNDERSCORE;
		if (r < 6) return hex_char(4'($urandom_range(0, 15)), 1'($urandom_range(0, 1)));
		return 8'($urandom_range(0, 255));
	endfunction

	// Queue the buffered component, closing it by last or by an empty word
	task automatic flush_component(logic close_empty);
		int n;
		n = comp_buf.size();
		for (int i = 0; i < n; i++)
			push_word(comp_buf[i].value, (i == n - 1) && !close_empty && n != 0, 1'b0);
		if (close_empty || n == 0)
			push_word(8'($urandom_range(0, 255)), 1'($urandom_range(0, 1)), 1'b1);
		comp_buf.delete();
	endtask

	task automatic buf_char(logic [7:0] c);
		in_word_t w;
		w.value = c;
		w.last  = 1'b0;
		w.empty = 1'b0;
		comp_buf.push_back(w);
	endtask

	task automatic gen_escape_phase(int n);
		int len;
		words_queued = 0;
		while (words_queued < n) begin
			len = $urandom_range(0, 5);
			for (int i = 0; i < len; i++)
				buf_char(($urandom_range(0, 9) < 4) ? pick_word_char() :
					8'($urandom_range(0, 255)));
			flush_component(len == 0 || $urandom_range(0, 7) == 0);
		end
	endtask

	task automatic gen_unescape_phase(int n);
		int         len;
		logic [7:0] raw;
		words_queued = 0;
		while (words_queued < n) begin
			if ($urandom_range(0, 9) < 7) begin
				// well-formed escaped component with random content
				len = $urandom_range(0, 4);
				for (int i = 0; i < len; i++) begin
					if ($urandom_range(0, 2) == 0) begin
						buf_char(pick_word_char());
					end else begin
						raw = 8'($urandom_range(0, 255));
						buf_char(UNDERSCORE);
						buf_char(hex_char(raw[7:4], 1'($urandom_range(0, 1))));
						buf_char(hex_char(raw[3:0], 1'($urandom_range(0, 1))));
					end
				end
				if (len == 0 && $urandom_range(0, 1)) buf_char(UNDERSCORE);
				flush_component(comp_buf.size() == 0);
			end else begin
				// broken sequences and stray underscores
				len = $urandom_range(1, 6);
				for (int i = 0; i < len; i++) buf_char(pick_noise_char());
				flush_component($urandom_range(0, 5) == 0);
			end
		end
	endtask

	// Sometimes leave a component open so the next direction write aborts it
	task automatic leave_open_tail();
		if ($urandom_range(0, 1)) begin
			push_word(UNDERSCORE, 1'b0, 1'b0);
			if ($urandom_range(0, 1)) push_word(pick_noise_char(), 1'b0, 1'b0);
		end
	endtask

	task automatic wait_quiet();
		do @(posedge clk);
		while (in_word_q.size() != 0 || in_valid || pending_result_words.size() != 0);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	task automatic write_direction(logic v);
		@(posedge clk);
		cfg_valid <= 1'b1;
		direction <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
	endtask

	// ---------------------------------------------------------------- input driver

	always @(posedge clk) begin : drive_input
		in_word_t nxt;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_ready) begin
			if (in_word_q.size() != 0 && $urandom_range(0, 99) >= gap_pct) begin
				nxt = in_word_q.pop_front();
				in_valid <= 1'b1;
				in_byte  <= nxt.value;
				in_last  <= nxt.last;
				in_empty <= nxt.empty;
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// Result back-pressure
	always @(posedge clk) begin
		res_ready <= arst_n && ($urandom_range(0, 99) >= stall_pct);
	end

	// ---------------------------------------------------------------- monitor

	always @(posedge clk) begin : check_results
		word_t want;
		if (arst_n) begin
			if (res_valid && res_ready) begin
				if (pending_result_words.size() == 0) begin
					$display("%0t unexpected word: got byte=%h valid=%b last=%b err=%b",
						$time, out_byte, out_valid, out_last, out_error);
					errors++;
				end else begin
					want = pending_result_words.pop_front();
					if (out_byte !== want.data || out_valid !== want.vld ||
						out_last !== want.last || out_error !== want.err) begin
						$display("%0t mismatch: expected %h/%b/%b/%b got %h/%b/%b/%b",
							$time, want.data, want.vld, want.last, want.err,
							out_byte, out_valid, out_last, out_error);
						errors++;
					end
				end
			end
			// direction write aborts any open component
			if (cfg_valid && cfg_ready) begin
				cur_dir    = direction;
				held_n     = 2'd0;
				held_ch    = 8'h00;
				comp_fresh = 1'b1;
			end
			if (in_valid && in_ready) codec_step(in_byte, in_last, in_empty);
		end
	end

	// Watchdog on cycles with no handshake at all
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (res_valid && res_ready) || (cfg_valid && cfg_ready)) begin
			idle_cycles <= 0;
		end else if (idle_cycles >= WATCHDOG_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end else begin
			idle_cycles <= idle_cycles + 1;
		end
	end

	// ---------------------------------------------------------------- sequence

	initial begin : run_phases
		logic phase_dir[NUM_PHASES] = '{1'b0, 1'b1, 1'b1, 1'b0, 1'b0, 1'b1, 1'b1, 1'b0};
		int   phase_gap[4]          = '{0, 79, 0, 28};
		int   phase_stall[4]        = '{0, 0, 79, 28};
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// escape straight after reset: empty at start, extremes, empty after bytes
		push_word(8'hA5, 1'b1, 1'b1);
		push_word("a", 1'b0, 1'b0);
		push_word(8'h00, 1'b0, 1'b0);
		push_word(8'hFF, 1'b0, 1'b0);
		push_word("9", 1'b1, 1'b0);
		push_word(UNDERSCORE, 1'b0, 1'b0);
		push_word(8'h3C, 1'b0, 1'b1);
		wait_quiet();

		// unescape corner cases
		write_direction(DIR_UNESCAPE);
		push_word(8'h00, 1'b1, 1'b1);
		push_word(UNDERSCORE, 1'b1, 1'b0);
		push_word(UNDERSCORE, 1'b0, 1'b0);
		push_word("F", 1'b0, 1'b0);
		push_word("f", 1'b1, 1'b0);
		push_word(UNDERSCORE, 1'b0, 1'b0);
		push_word("4", 1'b1, 1'b0);
		push_word("a", 1'b0, 1'b0);
		push_word(UNDERSCORE, 1'b1, 1'b0);
		push_word(UNDERSCORE, 1'b0, 1'b0);
		push_word("4", 1'b0, 1'b0);
		push_word("g", 1'b1, 1'b0);
		push_word(UNDERSCORE, 1'b0, 1'b0);
		push_word(8'hFF, 1'b0, 1'b1);
		push_word(UNDERSCORE, 1'b0, 1'b0);
		push_word(UNDERSCORE, 1'b0, 1'b0);
		push_word("0", 1'b0, 1'b0);
		push_word("0", 1'b1, 1'b0);
		push_word(UNDERSCORE, 1'b0, 1'b0);
		wait_quiet();

		// random phases over both directions and all idling patterns
		for (int p = 0; p < NUM_PHASES; p++) begin
			write_direction(phase_dir[p]);
			gap_pct   = phase_gap[p / 2];
			stall_pct = phase_stall[p / 2];
			if (phase_dir[p] == DIR_ESCAPE) gen_escape_phase(PHASE_WORDS);
			else gen_unescape_phase(PHASE_WORDS);
			leave_open_tail();
			wait_quiet();
		end

		if (pending_result_words.size() != 0) begin
			$display("%0t %0d expected words never arrived", $time,
				pending_result_words.size());
			errors++;
		end
		if (errors == 0) $display("TB_OK");
		else $display("TB_ERROR");
		$finish;
	end

endmodule
